// File: design/mpq_pkg.sv
`timescale 1ns / 1ps

package mpq_pkg;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] item_data;
    logic signed [31:0] item_priority;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_data;
    logic signed [31:0] out_priority;
    logic [7:0]         occupancy;
  } res_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } entry_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } ctl_t;

endpackage

// File: design/mpq_cell.sv
`timescale 1ns / 1ps

module mpq_cell #(
  parameter int DEPTH = 128,
  parameter int IDX   = 0
) (
  input  logic                         clk,
  input  mpq_pkg::ctl_t                ctl,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  mpq_pkg::entry_t              left_entry,
  input  logic                         left_ins,
  input  mpq_pkg::entry_t              right_entry,
  output mpq_pkg::entry_t              entry,
  output logic                         ins
);
  import mpq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // New item goes ahead of this cell if the cell is empty or holds a lower priority.
  // Equal priority stays ahead, which keeps arrival order among ties.
  assign ins = (count <= CW'(IDX)) || (ctl.item.prio > entry.prio);

  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      if (ins) begin
        entry <= left_ins ? left_entry : ctl.item;
      end
    end else if (ctl.deq) begin
      entry <= right_entry;
    end
  end

endmodule

// File: design/max_priority_queue.sv
`timescale 1ns / 1ps

// Bounded max-priority queue built as a sorted row of DEPTH cells.
// Command channel (cmd_valid / cmd_stall / cmd): each item is an enqueue of a
// data word with a signed priority, or a dequeue of the highest priority entry.
// Among equal priorities the earliest enqueued entry leaves first.
// Result channel (res_valid / res_stall / res): one item per command carrying
// status (ok, overflow, underflow), the removed entry on a good dequeue (zero
// otherwise) and the occupancy after the command.
// The result is registered at the edge that accepts the command. Throughput is
// one command per cycle while cmd_stall is low; every cell compares the new
// priority against its own entry and shifts by one place, all in parallel.
// A stalled result holds in the output register and cmd_stall rises until it
// is taken; a result being taken frees the register for the next command in
// the same cycle.
// Reset empties the queue and drops any pending result; cell contents are left
// as they were and are never read beyond the occupancy.
module max_priority_queue #(
  parameter int DEPTH = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  mpq_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output mpq_pkg::res_t res
);
  import mpq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          full;
  logic          empty;
  logic          is_enq;
  ctl_t          ctl;
  entry_t        cell_entry [DEPTH];
  logic          cell_ins   [DEPTH];
  logic [CW+7:0] occ_ext;

  assign cmd_stall = res_valid && res_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign is_enq    = (cmd.kind == OP_ENQ);
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);

  assign ctl.enq       = accept && is_enq && !full;
  assign ctl.deq       = accept && !is_enq && !empty;
  assign ctl.item.data = cmd.item_data;
  assign ctl.item.prio = cmd.item_priority;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      entry_t left_e;
      logic   left_i;
      entry_t right_e;
      if (i == 0) begin : g_head
        assign left_e = ctl.item;
        assign left_i = 1'b0;
      end else begin : g_body
        assign left_e = cell_entry[i-1];
        assign left_i = cell_ins[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
        assign right_e = ctl.item;
      end else begin : g_mid
        assign right_e = cell_entry[i+1];
      end
      mpq_cell #(
        .DEPTH (DEPTH),
        .IDX   (i)
      ) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .count       (count),
        .left_entry  (left_e),
        .left_ins    (left_i),
        .right_entry (right_e),
        .entry       (cell_entry[i]),
        .ins         (cell_ins[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctl.enq) begin
      count_next = count + CW'(1);
    end else if (ctl.deq) begin
      count_next = count - CW'(1);
    end
  end

  assign occ_ext = {8'd0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.occupancy    <= occ_ext[7:0];
      res.out_data     <= '0;
      res.out_priority <= '0;
      if (is_enq) begin
        res.status <= full ? ST_OVERFLOW : ST_OK;
      end else if (empty) begin
        res.status <= ST_UNDERFLOW;
      end else begin
        res.status       <= ST_OK;
        res.out_data     <= cell_entry[0].data;
        res.out_priority <= cell_entry[0].prio;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("entry count beyond depth");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.enq |=> count == $past(count) + CW'(1)) else $error("enqueue did not add an entry");

  a_deq_shrinks: assert property (@(posedge clk) disable iff (rst)
    ctl.deq |=> count == $past(count) - CW'(1)) else $error("dequeue did not remove an entry");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    count >= CW'(2) |-> cell_entry[0].prio >= cell_entry[1].prio)
    else $error("head cells out of priority order");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_UNDERFLOW |-> res.occupancy == 8'd0)
    else $error("underflow reported with entries held");

endmodule
